// ===== src/joystick_polar_motor_mixer_defines.svh =====
// Assertion macros shared by the joystick mixer checkers.
// Needs signals named clk and rst_n in the scope of use.
`ifndef JOYSTICK_POLAR_MOTOR_MIXER_DEFINES_SVH
`define JOYSTICK_POLAR_MOTOR_MIXER_DEFINES_SVH

// same-cycle implication, inactive during reset
`define JPM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jpm check failed");

// next-cycle implication, inactive during reset
`define JPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jpm check failed");

`endif

// ===== src/jpm_pkg.sv =====
// Shared types and constants of the joystick polar motor mixer.
// No dependencies.
package jpm_pkg;

    localparam int REG_COUNT    = 8;
    localparam int ADDR_W       = 5;
    localparam int SPEED_W      = 11;
    localparam int OUT_LIMIT    = 724;
    localparam int CORDIC_STEPS = 15;
    localparam int ANGLE_W      = 16;
    localparam int MAG_W        = 16;
    localparam int VAL_W        = 16;
    localparam int SECT_W       = 3;

    // Binary angles of the four axis directions
    localparam logic [ANGLE_W-1:0] ANG_EAST  = 16'd0;
    localparam logic [ANGLE_W-1:0] ANG_NORTH = 16'd16384;
    localparam logic [ANGLE_W-1:0] ANG_WEST  = 16'd32768;
    localparam logic [ANGLE_W-1:0] ANG_SOUTH = 16'd49152;

    // atan(2^-i) in units of a turn / 65536
    localparam logic [ANGLE_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1
    };

    localparam logic [31:0] PAIR_RESET [REG_COUNT] = '{
        32'd1073790976, 32'd536870912, 32'd1073758208, 32'd8192,
        32'd3221241856, 32'd3758096384, 32'd3221274624, 32'd57344
    };

    typedef logic [31:0] pair_t;
    typedef pair_t pair_arr_t [REG_COUNT];
    typedef logic signed [SPEED_W-1:0] speed_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [MAG_W-1:0]   mag;
    } polar_t;

endpackage

// ===== src/jpm_ifs.sv =====
// Stream interfaces of the joystick mixer: joystick samples in, motor speeds out.
// Depends on jpm_pkg.
interface jpm_joy_if #(parameter int COORD_BITS = 10) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] joy_x;
    logic signed [COORD_BITS-1:0] joy_y;

    modport source (output valid, joy_x, joy_y, input ready);
    modport sink (input valid, joy_x, joy_y, output ready);
endinterface

interface jpm_speed_if import jpm_pkg::*; ();
    logic   valid;
    logic   ready;
    speed_t left_speed;
    speed_t right_speed;

    modport source (output valid, left_speed, right_speed, input ready);
    modport sink (input valid, left_speed, right_speed, output ready);
endinterface

// ===== src/jpm_cfg_regs.sv =====
// APB register file holding the eight packed left/right point values.
// Depends on jpm_pkg.
module jpm_cfg_regs import jpm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pair_arr_t         pairs
);

    pair_arr_t pairs_reg;
    logic [SECT_W-1:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign prdata = pairs_reg[idx];
    assign pairs  = pairs_reg;

    // write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_reg <= PAIR_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            pairs_reg[idx] <= pwdata;
        end
    end

endmodule

// ===== src/jpm_polar.sv =====
// Polar front end: pipelined vectoring CORDIC for the angle, pipelined
// restoring square root for the floored magnitude. Depends on jpm_pkg.
module jpm_polar import jpm_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output polar_t                       out_polar
);

    localparam int CW   = COORD_BITS + 19;
    localparam int SQ_W = 2 * COORD_BITS;
    localparam int NIT  = (COORD_BITS > CORDIC_STEPS) ? COORD_BITS : CORDIC_STEPS;
    localparam int NST  = NIT + 1;

    logic                      vld_reg  [NST];
    logic signed [CW-1:0]      cx_reg   [NST];
    logic signed [CW-1:0]      cy_reg   [NST];
    logic [ANGLE_W-1:0]        z_reg    [NST];
    logic [SQ_W-1:0]           rem_reg  [NST];
    logic [SQ_W-1:0]           root_reg [NST];
    logic                      axis_reg [NST];
    logic [ANGLE_W-1:0]        axang_reg[NST];
    logic [NST:0]              en;

    // a stage moves when empty or when the next one moves
    always_comb
    begin
        en[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    // stage 0: half-turn fold, axis detect, squared radius
    logic signed [CW-1:0]   xw, yw;
    logic signed [SQ_W-1:0] xe, ye;
    logic [SQ_W-1:0]        sum_next;
    logic                   xneg;
    logic                   axis_next;
    logic [ANGLE_W-1:0]     axang_next;

    always_comb
    begin
        xw         = CW'(x) <<< 16;
        yw         = CW'(y) <<< 16;
        xe         = SQ_W'(x);
        ye         = SQ_W'(y);
        sum_next   = $unsigned(xe * xe) + $unsigned(ye * ye);
        xneg       = x[COORD_BITS-1];
        axis_next  = (x == '0) || (y == '0);
        if (y == '0)
        begin
            axang_next = xneg ? ANG_WEST : ANG_EAST;
        end
        else
        begin
            axang_next = y[COORD_BITS-1] ? ANG_SOUTH : ANG_NORTH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cx_reg[0]    <= xneg ? -xw : xw;
            cy_reg[0]    <= xneg ? -yw : yw;
            z_reg[0]     <= xneg ? ANG_WEST : ANG_EAST;
            rem_reg[0]   <= sum_next;
            root_reg[0]  <= '0;
            axis_reg[0]  <= axis_next;
            axang_reg[0] <= axang_next;
        end
    end

    // a CORDIC iteration and a root digit per stage, while any remain
    for (genvar k = 1; k < NST; k++)
    begin : g_stage
        localparam int I = k - 1;
        logic signed [CW-1:0] cx_next, cy_next;
        logic [ANGLE_W-1:0]   z_next;
        logic [SQ_W-1:0]      rem_next, root_next;

        if (I < CORDIC_STEPS)
        begin : g_cordic
            always_comb
            begin
                if (!cy_reg[k-1][CW-1])
                begin
                    cx_next = cx_reg[k-1] + (cy_reg[k-1] >>> I);
                    cy_next = cy_reg[k-1] - (cx_reg[k-1] >>> I);
                    z_next  = z_reg[k-1] + ATAN_TURN[I];
                end
                else
                begin
                    cx_next = cx_reg[k-1] - (cy_reg[k-1] >>> I);
                    cy_next = cy_reg[k-1] + (cx_reg[k-1] >>> I);
                    z_next  = z_reg[k-1] - ATAN_TURN[I];
                end
            end
        end
        else
        begin : g_cpass
            assign cx_next = cx_reg[k-1];
            assign cy_next = cy_reg[k-1];
            assign z_next  = z_reg[k-1];
        end

        if (I < COORD_BITS)
        begin : g_sqrt
            localparam logic [SQ_W-1:0] BIT_W = SQ_W'(1) << (2 * (COORD_BITS - 1 - I));
            logic [SQ_W:0] trial;
            logic          fits;

            assign trial = {1'b0, root_reg[k-1]} + {1'b0, BIT_W};
            assign fits  = {1'b0, rem_reg[k-1]} >= trial;
            assign rem_next  = fits ? rem_reg[k-1] - trial[SQ_W-1:0] : rem_reg[k-1];
            assign root_next = fits ? (root_reg[k-1] >> 1) + BIT_W : root_reg[k-1] >> 1;
        end
        else
        begin : g_spass
            assign rem_next  = rem_reg[k-1];
            assign root_next = root_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                cx_reg[k]    <= cx_next;
                cy_reg[k]    <= cy_next;
                z_reg[k]     <= z_next;
                rem_reg[k]   <= rem_next;
                root_reg[k]  <= root_next;
                axis_reg[k]  <= axis_reg[k-1];
                axang_reg[k] <= axang_reg[k-1];
            end
        end
    end

    // axis samples take the exact angle
    assign out_valid       = vld_reg[NST-1];
    assign out_polar.angle = axis_reg[NST-1] ? axang_reg[NST-1] : z_reg[NST-1];
    assign out_polar.mag   = MAG_W'(root_reg[NST-1]);

endmodule

// ===== src/jpm_mix.sv =====
// Sector lookup, linear interpolation of the point values and scaling by the
// magnitude, five pipeline stages. Depends on jpm_pkg.
module jpm_mix import jpm_pkg::*; #(
    parameter int NUM_POINTS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  polar_t    in_polar,
    input  pair_arr_t pairs,
    output logic      out_valid,
    input  logic      out_ready,
    output speed_t    left_speed,
    output speed_t    right_speed
);

    localparam int NST   = 5;
    localparam int POS_W = ANGLE_W + SECT_W;
    localparam int VQ_W  = 35;
    localparam int LO_W  = 18;
    localparam int HI_W  = VQ_W - LO_W;
    localparam int PP_W  = MAG_W + LO_W;
    localparam int PR_W  = PP_W + LO_W;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_in;
    logic [NST:0]   en;

    always_comb
    begin
        en[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NST-1];

    // valid bit entering each stage
    assign vld_in = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    // stage 0: sector and fraction
    logic [POS_W-1:0]   pos;
    logic [SECT_W-1:0]  sect_reg, next_reg;
    logic [15:0]        frac0_reg;
    logic [MAG_W-1:0]   mag0_reg;

    assign pos = POS_W'(in_polar.angle) * POS_W'(NUM_POINTS);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sect_reg  <= pos[POS_W-1:ANGLE_W];
            next_reg  <= (pos[POS_W-1:ANGLE_W] == SECT_W'(NUM_POINTS - 1)) ? '0
                         : pos[POS_W-1:ANGLE_W] + 1'b1;
            frac0_reg <= pos[ANGLE_W-1:0];
            mag0_reg  <= in_polar.mag;
        end
    end

    // stage 1: fetch both points, take the slope
    logic signed [VAL_W-1:0] p0l, p0r, p1l, p1r;
    logic signed [VAL_W-1:0] p0l_reg, p0r_reg;
    logic signed [VAL_W:0]   dl_reg, dr_reg;
    logic [15:0]             frac1_reg;
    logic [MAG_W-1:0]        mag1_reg;

    assign p0l = pairs[sect_reg][31:16];
    assign p0r = pairs[sect_reg][15:0];
    assign p1l = pairs[next_reg][31:16];
    assign p1r = pairs[next_reg][15:0];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p0l_reg   <= p0l;
            p0r_reg   <= p0r;
            dl_reg    <= (VAL_W+1)'(p1l) - (VAL_W+1)'(p0l);
            dr_reg    <= (VAL_W+1)'(p1r) - (VAL_W+1)'(p0r);
            frac1_reg <= frac0_reg;
            mag1_reg  <= mag0_reg;
        end
    end

    // stage 2: interpolated value in signed Q4.30
    logic signed [16:0]     fs;
    logic signed [VQ_W-1:0] vql_reg, vqr_reg;
    logic [MAG_W-1:0]       mag2_reg;

    assign fs = $signed({1'b0, frac1_reg});

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            vql_reg  <= (VQ_W'(p0l_reg) <<< 16) + VQ_W'(dl_reg * fs);
            vqr_reg  <= (VQ_W'(p0r_reg) <<< 16) + VQ_W'(dr_reg * fs);
            mag2_reg <= mag1_reg;
        end
    end

    // stage 3: magnitude times value, split in high and low partials
    logic signed [MAG_W:0]  ms;
    logic signed [PP_W-1:0] hl_reg, hr_reg;
    logic [PP_W-1:0]        ll_reg, lr_reg;

    assign ms = $signed({1'b0, mag2_reg});

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            hl_reg <= PP_W'(ms * $signed(vql_reg[VQ_W-1:LO_W]));
            hr_reg <= PP_W'(ms * $signed(vqr_reg[VQ_W-1:LO_W]));
            ll_reg <= PP_W'(mag2_reg) * PP_W'(vql_reg[LO_W-1:0]);
            lr_reg <= PP_W'(mag2_reg) * PP_W'(vqr_reg[LO_W-1:0]);
        end
    end

    // stage 4: sum, truncate toward zero, clamp
    function automatic speed_t scale_out(input logic signed [PP_W-1:0] hi,
                                         input logic [PP_W-1:0] lo);
        logic signed [PR_W-1:0] prod;
        logic signed [PR_W-1:0] biased;
        logic signed [PR_W-31:0] r;
        begin
            prod   = $signed({hi, {LO_W{1'b0}}}) + $signed({{LO_W{1'b0}}, lo});
            biased = prod + (prod[PR_W-1] ? PR_W'((1 << 30) - 1) : PR_W'(0));
            r      = biased[PR_W-1:30];
            if (r > (PR_W-30)'(OUT_LIMIT))
            begin
                scale_out = SPEED_W'(OUT_LIMIT);
            end
            else if (r < -(PR_W-30)'(OUT_LIMIT))
            begin
                scale_out = -SPEED_W'(OUT_LIMIT);
            end
            else
            begin
                scale_out = r[SPEED_W-1:0];
            end
        end
    endfunction

    speed_t left_reg, right_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            left_reg  <= scale_out(hl_reg, ll_reg);
            right_reg <= scale_out(hr_reg, lr_reg);
        end
    end

    assign left_speed  = left_reg;
    assign right_speed = right_reg;

endmodule

// ===== src/joystick_polar_motor_mixer.sv =====
// Joystick polar motor mixer top level.
// Depends on jpm_pkg, jpm_ifs, jpm_cfg_regs, jpm_polar and jpm_mix.
//
// Usage:
//   joy   : sample stream (joy_x, joy_y), valid/ready, transfer when both high.
//   speed : result stream (left_speed, right_speed), one result per sample.
//   APB   : eight point registers at byte address 4*k, write only while idle.
// The datapath has NIT + 6 register stages, NIT being the larger of 15 (CORDIC
// iterations) and COORD_BITS (root digits). Throughput is one sample per cycle
// while the receiver takes results; each stage of the CORDIC/root pipeline and
// of the mixing pipeline holds one item.
// Reset clears all stage valid bits and loads the point defaults.
// When the receiver stalls, full stages hold their data and empty stages
// keep filling; joy.ready drops only when every stage is occupied.
module joystick_polar_motor_mixer import jpm_pkg::*; #(
    parameter int NUM_POINTS = 8,
    parameter int COORD_BITS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    jpm_joy_if.sink           joy,
    jpm_speed_if.source       speed,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    pair_arr_t pairs;
    polar_t    polar;
    logic      polar_valid;
    logic      polar_ready;

    // configuration registers
    jpm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pairs   (pairs)
    );

    // angle and magnitude
    jpm_polar #(.COORD_BITS(COORD_BITS)) u_polar (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (joy.valid),
        .in_ready  (joy.ready),
        .x         (joy.joy_x),
        .y         (joy.joy_y),
        .out_valid (polar_valid),
        .out_ready (polar_ready),
        .out_polar (polar)
    );

    // interpolation and scaling
    jpm_mix #(.NUM_POINTS(NUM_POINTS)) u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (polar_valid),
        .in_ready    (polar_ready),
        .in_polar    (polar),
        .pairs       (pairs),
        .out_valid   (speed.valid),
        .out_ready   (speed.ready),
        .left_speed  (speed.left_speed),
        .right_speed (speed.right_speed)
    );

endmodule

// ===== src/jpm_checker.sv =====
// Port-level checks of the joystick mixer, bound to the top level.
// Depends on jpm_pkg and joystick_polar_motor_mixer_defines.svh.
`include "joystick_polar_motor_mixer_defines.svh"

module jpm_checker import jpm_pkg::*; (
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input speed_t left_speed,
    input speed_t right_speed
);

    // input backs up only when the whole pipeline is full and stalled
    `JPM_ASSERT_NOW(a_ready_only_on_stall, !in_ready, out_valid && !out_ready)

    // results stay within the clamp range
    `JPM_ASSERT_NOW(a_speed_range, out_valid, (left_speed <= 11'sd724) && (left_speed >= -11'sd724) && (right_speed <= 11'sd724) && (right_speed >= -11'sd724))

    // a stalled result stays offered
    `JPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // a stalled result keeps its value
    `JPM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(left_speed) && $stable(right_speed))

endmodule

bind joystick_polar_motor_mixer jpm_checker u_jpm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (joy.valid),
    .in_ready    (joy.ready),
    .out_valid   (speed.valid),
    .out_ready   (speed.ready),
    .left_speed  (speed.left_speed),
    .right_speed (speed.right_speed)
);
